FILE: src/rtc_pkg.sv
// shared types and constants for the route cheapest-insertion block
`timescale 1ns / 1ps
package rtc_pkg;

  localparam int MAX_CUSTOMERS_DEF = 64;
  localparam int FRAC_BITS_DEF     = 8;

  localparam int S_TDATA_W = 80;
  localparam int M_TDATA_W = 144;
  localparam int CFG_IDX_W = 3;
  localparam int CFG_W     = 24;
  localparam int TOT_W     = 22;
  localparam logic [TOT_W-1:0] TOT_MAX = '1;

  localparam logic [1:0] REQ_CLEAR = 2'd0;
  localparam logic [1:0] REQ_BEST  = 2'd1;
  localparam logic [1:0] REQ_AT    = 2'd2;
  localparam logic [1:0] REQ_POP   = 2'd3;

  localparam logic [1:0] STAT_OK     = 2'd0;
  localparam logic [1:0] STAT_FULL   = 2'd1;
  localparam logic [1:0] STAT_EMPTY  = 2'd2;
  localparam logic [1:0] STAT_BADPOS = 2'd3;

  localparam logic [CFG_IDX_W-1:0] CFG_DEPOT_X     = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_DEPOT_Y     = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_MAX_LENGTH  = 3'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_MAX_LOAD    = 3'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_MAX_SERVICE = 3'd4;

  typedef enum logic [1:0] {RD_PREV, RD_NEXT, RD_SHIFT} rd_sel_t;
  typedef enum logic [1:0] {DS_PC, DS_CN, DS_PN} dist_sel_t;
  typedef enum logic [1:0] {ACC_HOLD, ACC_SET, ACC_ADD, ACC_SUB} acc_op_t;
  typedef enum logic [2:0] {IDX_HOLD, IDX_ZERO, IDX_LAST, IDX_POS, IDX_INC, IDX_BEST} idx_op_t;
  typedef enum logic [2:0] {RES_NONE, RES_CLR, RES_ERR, RES_POP, RES_INS} res_op_t;

  typedef struct packed {
    logic      load;
    rd_sel_t   rd_sel;
    logic      ld_prv;
    logic      ld_nxt;
    logic      ld_pop;
    logic      dist_start;
    dist_sel_t dist_sel;
    acc_op_t   acc_op;
    idx_op_t   idx_op;
    logic      scan_upd;
    logic      j_init;
    logic      j_dec;
    logic      wr_shift;
    logic      wr_new;
    res_op_t   res_op;
  } cmd_t;

  typedef struct packed {
    logic [1:0] req;
    logic       count_zero;
    logic       full;
    logic       pos_bad;
    logic       idx_last;
    logic       j_done;
    logic       dist_done;
  } sts_t;

endpackage

FILE: src/rtc_ram.sv
// generic single-write, single-read ram with registered read
`timescale 1ns / 1ps
module rtc_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 64
) (
  input  logic                     clk,
  input  logic                     wr_en,
  input  logic [$clog2(DEPTH)-1:0] wr_addr,
  input  logic [WIDTH-1:0]         wr_data,
  input  logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic [WIDTH-1:0]         rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    rd_data <= mem[rd_addr];
  end

endmodule

FILE: src/rtc_dist.sv
// euclidean distance unit: squares, then bit-serial integer square root
`timescale 1ns / 1ps
module rtc_dist #(
  parameter int FRAC_BITS = rtc_pkg::FRAC_BITS_DEF
) (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            start,
  input  logic signed [11:0]              ax,
  input  logic signed [11:0]              ay,
  input  logic signed [11:0]              bx,
  input  logic signed [11:0]              by,
  output logic                            done,
  output logic [(26+2*FRAC_BITS)/2-1:0]   root
);

  localparam int SQ_W   = 26 + 2 * FRAC_BITS;
  localparam int ROOT_W = SQ_W / 2;
  localparam int CW     = $clog2(ROOT_W + 1);

  typedef enum logic [1:0] {P_IDLE, P_SQ, P_LD, P_IT} phase_t;

  phase_t             phase;
  logic signed [12:0] dx, dy;
  logic signed [25:0] prod_x, prod_y;
  logic [23:0]        sqx, sqy;
  logic [SQ_W-1:0]    v, r, bit_r;
  logic [SQ_W:0]      trial;
  logic               ge;
  logic [CW-1:0]      cnt;

  assign prod_x = dx * dx;
  assign prod_y = dy * dy;
  assign trial  = {1'b0, r} + {1'b0, bit_r};
  assign ge     = {1'b0, v} >= trial;
  assign root   = r[ROOT_W-1:0];

  always_ff @(posedge clk) begin
    if (rst) begin
      phase <= P_IDLE;
      done  <= 1'b0;
    end else begin
      done <= 1'b0;
      case (phase)
        P_IDLE: begin
          if (start) begin
            dx    <= $signed({ax[11], ax}) - $signed({bx[11], bx});
            dy    <= $signed({ay[11], ay}) - $signed({by[11], by});
            phase <= P_SQ;
          end
        end
        P_SQ: begin
          sqx   <= prod_x[23:0];
          sqy   <= prod_y[23:0];
          phase <= P_LD;
        end
        P_LD: begin
          v     <= SQ_W'({1'b0, sqx} + {1'b0, sqy}) << (2 * FRAC_BITS);
          r     <= '0;
          bit_r <= SQ_W'(1) << (SQ_W - 2);
          cnt   <= CW'(ROOT_W);
          phase <= P_IT;
        end
        P_IT: begin
          if (ge) begin
            v <= v - trial[SQ_W-1:0];
            r <= (r >> 1) + bit_r;
          end else begin
            r <= r >> 1;
          end
          bit_r <= bit_r >> 2;
          cnt   <= cnt - CW'(1);
          if (cnt == CW'(1)) begin
            phase <= P_IDLE;
            done  <= 1'b1;
          end
        end
        default: phase <= P_IDLE;
      endcase
    end
  end

endmodule

FILE: src/rtc_datapath.sv
// route store, running totals, cost accumulation and result register
`timescale 1ns / 1ps
module rtc_datapath #(
  parameter int MAX_CUSTOMERS = rtc_pkg::MAX_CUSTOMERS_DEF,
  parameter int FRAC_BITS     = rtc_pkg::FRAC_BITS_DEF
) (
  input  logic                           clk,
  input  logic                           rst,
  input  logic [rtc_pkg::S_TDATA_W-1:0]  s_tdata,
  input  logic [1:0]                     s_tuser,
  input  logic                           cfg_we,
  input  logic [rtc_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [rtc_pkg::CFG_W-1:0]      cfg_data,
  input  rtc_pkg::cmd_t                  cmd,
  output rtc_pkg::sts_t                  sts,
  output logic [rtc_pkg::M_TDATA_W-1:0]  m_tdata,
  output logic [1:0]                     m_tuser
);

  localparam int AW     = $clog2(MAX_CUSTOMERS);
  localparam int IW     = $clog2(MAX_CUSTOMERS + 1);
  localparam int SQ_W   = 26 + 2 * FRAC_BITS;
  localparam int ROOT_W = SQ_W / 2;
  localparam int COST_W = ROOT_W + 2;
  localparam int DW     = COST_W + 1;
  localparam int TW     = rtc_pkg::TOT_W;

  logic [1:0]        req;
  logic signed [11:0] cur_x, cur_y, prv_x, prv_y, nxt_x, nxt_y;
  logic [15:0]       dem, srv, cid, pop_dem, pop_srv, pop_id;
  logic [6:0]        pos;
  logic signed [11:0] depot_x, depot_y;
  logic [23:0]       max_length;
  logic [TW-1:0]     max_load, max_service;
  logic [IW-1:0]     count, idx, j, at_a, at_f;
  logic [31:0]       length;
  logic [TW-1:0]     load, service;
  logic signed [COST_W-1:0] acc, best_a, best_f, dist_ext;
  logic              have_f, have_eff;

  logic [1:0]        r_status;
  logic [6:0]        r_used, r_count;
  logic [31:0]       r_delta, r_len;
  logic              r_feas;
  logic [15:0]       r_rid;
  logic [TW-1:0]     r_load, r_srv;

  logic [AW-1:0]     rd_addr, wr_addr;
  logic [IW-1:0]     rd_full;
  logic              wr_en;
  logic [23:0]       coord_rd, coord_wr;
  logic [47:0]       attr_rd, attr_wr;

  logic              d_start, d_done;
  logic signed [11:0] d_ax, d_ay, d_bx, d_by;
  logic [ROOT_W-1:0] d_dist;

  logic signed [DW-1:0] ins_delta, pop_delta;
  logic [31:0]       nl_ins, nl_pop;
  logic              ok_len, ok_load, ok_srv, feas, full;
  logic [TW:0]       load_sum, srv_sum;

  function automatic logic [31:0] len_clamp(input logic [31:0] len,
                                            input logic signed [DW-1:0] d);
    logic signed [33:0] s;
    s = $signed({2'b00, len}) + 34'(d);
    if (s < 0) len_clamp = '0;
    else if (s > $signed(34'h0FFFFFFFF)) len_clamp = '1;
    else len_clamp = s[31:0];
  endfunction

  function automatic logic [TW-1:0] sat_add(input logic [TW-1:0] a, input logic [15:0] b);
    logic [TW:0] s;
    s = {1'b0, a} + (TW+1)'(b);
    sat_add = (s > (TW+1)'(rtc_pkg::TOT_MAX)) ? rtc_pkg::TOT_MAX : s[TW-1:0];
  endfunction

  function automatic logic [TW-1:0] sat_sub(input logic [TW-1:0] a, input logic [15:0] b);
    sat_sub = (a > TW'(b)) ? a - TW'(b) : '0;
  endfunction

  // store access
  always_comb begin
    case (cmd.rd_sel)
      rtc_pkg::RD_PREV:  rd_full = idx - IW'(1);
      rtc_pkg::RD_NEXT:  rd_full = idx;
      rtc_pkg::RD_SHIFT: rd_full = j - IW'(1);
      default:           rd_full = idx;
    endcase
  end
  assign rd_addr  = rd_full[AW-1:0];
  assign wr_en    = cmd.wr_shift | cmd.wr_new;
  assign wr_addr  = cmd.wr_shift ? j[AW-1:0] : idx[AW-1:0];
  assign coord_wr = cmd.wr_shift ? coord_rd : {cur_y, cur_x};
  assign attr_wr  = cmd.wr_shift ? attr_rd : {cid, srv, dem};

  rtc_ram #(.WIDTH(24), .DEPTH(MAX_CUSTOMERS)) u_coord_store (
    .clk(clk), .wr_en(wr_en), .wr_addr(wr_addr), .wr_data(coord_wr),
    .rd_addr(rd_addr), .rd_data(coord_rd)
  );

  rtc_ram #(.WIDTH(48), .DEPTH(MAX_CUSTOMERS)) u_attr_store (
    .clk(clk), .wr_en(wr_en), .wr_addr(wr_addr), .wr_data(attr_wr),
    .rd_addr(rd_addr), .rd_data(attr_rd)
  );

  // distance unit
  always_comb begin
    case (cmd.dist_sel)
      rtc_pkg::DS_PC: begin d_ax = prv_x; d_ay = prv_y; d_bx = cur_x; d_by = cur_y; end
      rtc_pkg::DS_CN: begin d_ax = cur_x; d_ay = cur_y; d_bx = nxt_x; d_by = nxt_y; end
      rtc_pkg::DS_PN: begin d_ax = prv_x; d_ay = prv_y; d_bx = nxt_x; d_by = nxt_y; end
      default:        begin d_ax = prv_x; d_ay = prv_y; d_bx = cur_x; d_by = cur_y; end
    endcase
  end
  assign d_start = cmd.dist_start;

  rtc_dist #(.FRAC_BITS(FRAC_BITS)) u_dist (
    .clk(clk), .rst(rst), .start(d_start),
    .ax(d_ax), .ay(d_ay), .bx(d_bx), .by(d_by),
    .done(d_done), .root(d_dist)
  );

  assign dist_ext = $signed({2'b00, d_dist});

  // limits
  assign ins_delta = DW'(acc);
  assign pop_delta = -ins_delta;
  assign nl_ins    = len_clamp(length, ins_delta);
  assign nl_pop    = len_clamp(length, pop_delta);
  assign load_sum  = {1'b0, load} + (TW+1)'(dem);
  assign srv_sum   = {1'b0, service} + (TW+1)'(srv);
  assign ok_len    = (max_length == '0) ||
                     (41'(nl_ins) <= (41'(max_length) << FRAC_BITS));
  assign ok_load   = load_sum <= {1'b0, max_load};
  assign ok_srv    = (max_service == '0) || (srv_sum <= {1'b0, max_service});
  assign feas      = ok_len & ok_load & ok_srv;
  assign have_eff  = (idx == '0) ? 1'b0 : have_f;
  assign full      = count >= IW'(MAX_CUSTOMERS);

  assign sts.req        = req;
  assign sts.count_zero = count == '0;
  assign sts.full       = full;
  assign sts.pos_bad    = 32'(pos) > 32'(count);
  assign sts.idx_last   = idx == (count - IW'(1));
  assign sts.j_done     = j == idx;
  assign sts.dist_done  = d_done;

  // item capture and working registers
  always_ff @(posedge clk) begin
    if (cmd.load) begin
      req   <= s_tuser;
      cur_x <= s_tdata[11:0];
      cur_y <= s_tdata[23:12];
      dem   <= s_tdata[39:24];
      srv   <= s_tdata[55:40];
      cid   <= s_tdata[71:56];
      pos   <= s_tdata[78:72];
    end
    if (cmd.ld_prv) begin
      prv_x <= (idx == '0) ? depot_x : coord_rd[11:0];
      prv_y <= (idx == '0) ? depot_y : coord_rd[23:12];
    end
    if (cmd.ld_nxt) begin
      nxt_x <= (idx < count) ? coord_rd[11:0]  : depot_x;
      nxt_y <= (idx < count) ? coord_rd[23:12] : depot_y;
    end
    if (cmd.ld_pop) begin
      cur_x   <= coord_rd[11:0];
      cur_y   <= coord_rd[23:12];
      nxt_x   <= depot_x;
      nxt_y   <= depot_y;
      pop_dem <= attr_rd[15:0];
      pop_srv <= attr_rd[31:16];
      pop_id  <= attr_rd[47:32];
    end
    case (cmd.acc_op)
      rtc_pkg::ACC_SET: acc <= dist_ext;
      rtc_pkg::ACC_ADD: acc <= acc + dist_ext;
      rtc_pkg::ACC_SUB: acc <= acc - dist_ext;
      default:          acc <= acc;
    endcase
    if (cmd.scan_upd) begin
      if (idx == '0 || acc < best_a) begin
        best_a <= acc;
        at_a   <= idx;
      end
      if (feas && (!have_eff || acc < best_f)) begin
        best_f <= acc;
        at_f   <= idx;
        have_f <= 1'b1;
      end else begin
        have_f <= have_eff;
      end
    end
    case (cmd.idx_op)
      rtc_pkg::IDX_ZERO: idx <= '0;
      rtc_pkg::IDX_LAST: idx <= count - IW'(1);
      rtc_pkg::IDX_POS:  idx <= IW'(pos);
      rtc_pkg::IDX_INC:  idx <= idx + IW'(1);
      rtc_pkg::IDX_BEST: idx <= have_f ? at_f : at_a;
      default:           idx <= idx;
    endcase
    if (cmd.j_init) begin
      j <= count;
    end else if (cmd.j_dec) begin
      j <= j - IW'(1);
    end
  end

  // configuration, totals and result register
  always_ff @(posedge clk) begin
    if (rst) begin
      depot_x     <= '0;
      depot_y     <= '0;
      max_length  <= '0;
      max_load    <= rtc_pkg::TOT_MAX;
      max_service <= '0;
      count       <= '0;
      length      <= '0;
      load        <= '0;
      service     <= '0;
    end else begin
      if (cfg_we) begin
        case (cfg_index)
          rtc_pkg::CFG_DEPOT_X:     depot_x     <= cfg_data[11:0];
          rtc_pkg::CFG_DEPOT_Y:     depot_y     <= cfg_data[11:0];
          rtc_pkg::CFG_MAX_LENGTH:  max_length  <= cfg_data[23:0];
          rtc_pkg::CFG_MAX_LOAD:    max_load    <= cfg_data[TW-1:0];
          rtc_pkg::CFG_MAX_SERVICE: max_service <= cfg_data[TW-1:0];
          default: ;
        endcase
      end
      case (cmd.res_op)
        rtc_pkg::RES_CLR: begin
          count   <= '0;
          length  <= '0;
          load    <= '0;
          service <= '0;
        end
        rtc_pkg::RES_POP: begin
          count   <= idx;
          length  <= nl_pop;
          load    <= sat_sub(load, pop_dem);
          service <= sat_sub(service, pop_srv);
        end
        rtc_pkg::RES_INS: begin
          count   <= count + IW'(1);
          length  <= nl_ins;
          load    <= sat_add(load, dem);
          service <= sat_add(service, srv);
        end
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    case (cmd.res_op)
      rtc_pkg::RES_CLR: begin
        r_status <= rtc_pkg::STAT_OK;
        r_used   <= '0;
        r_delta  <= '0;
        r_feas   <= 1'b0;
        r_rid    <= '0;
        r_len    <= '0;
        r_load   <= '0;
        r_srv    <= '0;
        r_count  <= '0;
      end
      rtc_pkg::RES_ERR: begin
        r_status <= (req == rtc_pkg::REQ_POP) ? rtc_pkg::STAT_EMPTY :
                    full ? rtc_pkg::STAT_FULL : rtc_pkg::STAT_BADPOS;
        r_used   <= '0;
        r_delta  <= '0;
        r_feas   <= 1'b0;
        r_rid    <= '0;
        r_len    <= length;
        r_load   <= load;
        r_srv    <= service;
        r_count  <= 7'(count);
      end
      rtc_pkg::RES_POP: begin
        r_status <= rtc_pkg::STAT_OK;
        r_used   <= 7'(idx);
        r_delta  <= 32'(pop_delta);
        r_feas   <= 1'b0;
        r_rid    <= pop_id;
        r_len    <= nl_pop;
        r_load   <= sat_sub(load, pop_dem);
        r_srv    <= sat_sub(service, pop_srv);
        r_count  <= 7'(idx);
      end
      rtc_pkg::RES_INS: begin
        r_status <= rtc_pkg::STAT_OK;
        r_used   <= 7'(idx);
        r_delta  <= 32'(ins_delta);
        r_feas   <= feas;
        r_rid    <= '0;
        r_len    <= nl_ins;
        r_load   <= sat_add(load, dem);
        r_srv    <= sat_add(service, srv);
        r_count  <= 7'(count + IW'(1));
      end
      default: ;
    endcase
  end

  assign m_tuser = r_status;
  assign m_tdata = {5'b0, r_count, r_srv, r_load, r_len, r_rid, r_feas, r_delta, r_used};

endmodule

FILE: src/rtc_ctrl.sv
// request sequencer: scan, evaluation, store shift and result handoff
`timescale 1ns / 1ps
module rtc_ctrl (
  input  logic          clk,
  input  logic          rst,
  input  logic          s_tvalid,
  output logic          s_tready,
  output logic          m_tvalid,
  input  logic          m_tready,
  input  rtc_pkg::sts_t sts,
  output rtc_pkg::cmd_t cmd
);

  typedef enum logic [4:0] {
    S_IDLE, S_DEC, S_EV_RP, S_EV_LP, S_EV_LN, S_D1, S_W1, S_D2, S_W2,
    S_D3, S_W3, S_NEXT, S_PICK, S_SH_CHK, S_SH_RD, S_SH_WR, S_WR_NEW, S_DONE
  } state_t;

  typedef enum logic [1:0] {PH_SCAN, PH_FINAL, PH_POP} phase_t;

  state_t            state;
  phase_t            ph;
  rtc_pkg::res_op_t  fin;
  logic              out_valid;
  logic              out_free;

  assign s_tready = state == S_IDLE;
  assign m_tvalid = out_valid;
  assign out_free = !out_valid || m_tready;

  always_comb begin
    cmd      = '0;
    cmd.load = s_tvalid && (state == S_IDLE);
    case (state)
      S_DEC: begin
        if (sts.req == rtc_pkg::REQ_POP) begin
          if (!sts.count_zero) cmd.idx_op = rtc_pkg::IDX_LAST;
        end else if (sts.req == rtc_pkg::REQ_AT) begin
          if (!sts.full && !sts.pos_bad) cmd.idx_op = rtc_pkg::IDX_POS;
        end else if (sts.req == rtc_pkg::REQ_BEST) begin
          if (!sts.full) cmd.idx_op = rtc_pkg::IDX_ZERO;
        end
      end
      S_EV_RP: cmd.rd_sel = rtc_pkg::RD_PREV;
      S_EV_LP: begin
        cmd.ld_prv = 1'b1;
        cmd.rd_sel = rtc_pkg::RD_NEXT;
      end
      S_EV_LN: begin
        if (ph == PH_POP) cmd.ld_pop = 1'b1;
        else cmd.ld_nxt = 1'b1;
      end
      S_D1: begin
        cmd.dist_start = 1'b1;
        cmd.dist_sel   = rtc_pkg::DS_PC;
      end
      S_W1: if (sts.dist_done) cmd.acc_op = rtc_pkg::ACC_SET;
      S_D2: begin
        cmd.dist_start = 1'b1;
        cmd.dist_sel   = rtc_pkg::DS_CN;
      end
      S_W2: if (sts.dist_done) cmd.acc_op = rtc_pkg::ACC_ADD;
      S_D3: begin
        cmd.dist_start = 1'b1;
        cmd.dist_sel   = rtc_pkg::DS_PN;
      end
      S_W3: if (sts.dist_done) cmd.acc_op = rtc_pkg::ACC_SUB;
      S_NEXT: begin
        if (ph == PH_SCAN) begin
          cmd.scan_upd = 1'b1;
          if (!sts.idx_last) cmd.idx_op = rtc_pkg::IDX_INC;
        end else if (ph == PH_FINAL) begin
          cmd.j_init = 1'b1;
        end
      end
      S_PICK:  cmd.idx_op = rtc_pkg::IDX_BEST;
      S_SH_RD: cmd.rd_sel = rtc_pkg::RD_SHIFT;
      S_SH_WR: begin
        cmd.wr_shift = 1'b1;
        cmd.j_dec    = 1'b1;
      end
      S_WR_NEW: cmd.wr_new = 1'b1;
      S_DONE:   if (out_free) cmd.res_op = fin;
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      ph        <= PH_SCAN;
      fin       <= rtc_pkg::RES_NONE;
      out_valid <= 1'b0;
    end else begin
      if (state == S_DONE && out_free) begin
        out_valid <= 1'b1;
      end else if (m_tready) begin
        out_valid <= 1'b0;
      end
      case (state)
        S_IDLE: if (s_tvalid) state <= S_DEC;
        S_DEC: begin
          if (sts.req == rtc_pkg::REQ_CLEAR) begin
            fin   <= rtc_pkg::RES_CLR;
            state <= S_DONE;
          end else if (sts.req == rtc_pkg::REQ_POP) begin
            if (sts.count_zero) begin
              fin   <= rtc_pkg::RES_ERR;
              state <= S_DONE;
            end else begin
              ph    <= PH_POP;
              state <= S_EV_RP;
            end
          end else if (sts.full || (sts.req == rtc_pkg::REQ_AT && sts.pos_bad)) begin
            fin   <= rtc_pkg::RES_ERR;
            state <= S_DONE;
          end else begin
            ph    <= (sts.req == rtc_pkg::REQ_AT || sts.count_zero) ? PH_FINAL : PH_SCAN;
            state <= S_EV_RP;
          end
        end
        S_EV_RP: state <= S_EV_LP;
        S_EV_LP: state <= S_EV_LN;
        S_EV_LN: state <= S_D1;
        S_D1:    state <= S_W1;
        S_W1:    if (sts.dist_done) state <= S_D2;
        S_D2:    state <= S_W2;
        S_W2:    if (sts.dist_done) state <= S_D3;
        S_D3:    state <= S_W3;
        S_W3:    if (sts.dist_done) state <= S_NEXT;
        S_NEXT: begin
          case (ph)
            PH_SCAN:  state <= sts.idx_last ? S_PICK : S_EV_RP;
            PH_FINAL: state <= S_SH_CHK;
            default: begin
              fin   <= rtc_pkg::RES_POP;
              state <= S_DONE;
            end
          endcase
        end
        S_PICK: begin
          ph    <= PH_FINAL;
          state <= S_EV_RP;
        end
        S_SH_CHK: state <= sts.j_done ? S_WR_NEW : S_SH_RD;
        S_SH_RD:  state <= S_SH_WR;
        S_SH_WR:  state <= S_SH_CHK;
        S_WR_NEW: begin
          fin   <= rtc_pkg::RES_INS;
          state <= S_DONE;
        end
        S_DONE: begin
          if (out_free) begin
            state <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

endmodule

FILE: src/route_cheapest_insertion.sv
// top level of the route store with cheapest feasible insertion
//
//  channel   dir  handshake         payload
//  s_*       in   tvalid / tready   tuser: req_type; tdata: request item
//  m_*       out  tvalid / tready   tuser: status; tdata: result item
//  cfg_*     in   cfg_we            cfg_index selects register, cfg_data
//
//  one item at a time; a position evaluation runs three distances in turn,
//  each of R = (26+2*FRAC_BITS)/2 square-root steps on the one distance unit
//  best insertion: (count+1) evaluations, plus S_SH_CHK, S_SH_RD, S_SH_WR per shifted entry
//  insert at position: one evaluation plus the shift; pop: one evaluation
//  a finished result waits in the output register while the next item is taken
//  rst is synchronous; store contents are not cleared, only count, totals and config
`timescale 1ns / 1ps
module route_cheapest_insertion #(
  parameter int MAX_CUSTOMERS = rtc_pkg::MAX_CUSTOMERS_DEF,
  parameter int FRAC_BITS     = rtc_pkg::FRAC_BITS_DEF
) (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           s_tvalid,
  output logic                           s_tready,
  // cust_x, cust_y, cust_demand, cust_service, cust_id, position, zero fill
  input  logic [rtc_pkg::S_TDATA_W-1:0]  s_tdata,
  // req_type
  input  logic [1:0]                     s_tuser,
  output logic                           m_tvalid,
  input  logic                           m_tready,
  // used_position, delta_cost, was_feasible, removed_id, total_length,
  // total_load, total_service, entry_count, zero fill
  output logic [rtc_pkg::M_TDATA_W-1:0]  m_tdata,
  // status
  output logic [1:0]                     m_tuser,
  input  logic                           cfg_we,
  input  logic [rtc_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [rtc_pkg::CFG_W-1:0]      cfg_data
);

  rtc_pkg::cmd_t cmd;
  rtc_pkg::sts_t sts;

  rtc_ctrl u_ctrl (
    .clk(clk), .rst(rst),
    .s_tvalid(s_tvalid), .s_tready(s_tready),
    .m_tvalid(m_tvalid), .m_tready(m_tready),
    .sts(sts), .cmd(cmd)
  );

  rtc_datapath #(.MAX_CUSTOMERS(MAX_CUSTOMERS), .FRAC_BITS(FRAC_BITS)) u_datapath (
    .clk(clk), .rst(rst),
    .s_tdata(s_tdata), .s_tuser(s_tuser),
    .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data),
    .cmd(cmd), .sts(sts),
    .m_tdata(m_tdata), .m_tuser(m_tuser)
  );

endmodule
